@@ rtl/rta_pkg.sv @@
// Shared types and constants for the request tag allocator.
// Depends on nothing; every other file in rtl/ imports it.
package rta_pkg;

  // Tag bit 7 selects the generation half; the low bits index inside a half.
  localparam int TAG_W       = 8;
  localparam int TAG_IDX_W   = 7;
  localparam int PAGE_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int GROUP_SIZE  = 8;
  localparam int GROUP_IDX_W = 3;

  typedef enum logic [2:0] {
    FN_BEGIN      = 3'd0,
    FN_ASSIGN     = 3'd1,
    FN_RESOLVE    = 3'd2,
    FN_RETIRE     = 3'd3,
    FN_INVALIDATE = 3'd4
  } rta_func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } rta_state_t;

  // Update request from the sequencer to the active-flag table.
  typedef struct packed {
    logic                 clear;
    logic                 set_en;
    logic                 clr_en;
    logic [TAG_IDX_W-1:0] idx;
  } rta_flag_cmd_t;

endpackage

@@ rtl/rta_flag_table.sv @@
// Active-flag table: one flip-flop per tag of a half, a registered lookup bit
// and a two-level registered search for the lowest free tag. Uses rta_pkg.
module rta_flag_table #(
  parameter int TAGS_PER_HALF = 128,
  parameter int IDX_W         = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    capture,
  input  logic [IDX_W-1:0]        look_idx,
  input  rta_pkg::rta_flag_cmd_t  cmd,
  output logic                    look_active,
  output logic                    free_found,
  output logic [IDX_W-1:0]        free_idx
);
  import rta_pkg::*;

  localparam int FLAG_N  = 1 << IDX_W;
  localparam int GROUPS  = (FLAG_N + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NPAD    = GROUPS * GROUP_SIZE;
  localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SEL_W   = GRP_W + GROUP_IDX_W;

  logic [NPAD-1:0]        flags_r;
  logic [NPAD-1:0]        flags_nxt;
  logic [NPAD-1:0]        busy_pad;
  logic [GROUPS-1:0]      grp_free_r;
  logic [GROUPS-1:0]      grp_free_nxt;
  logic [GROUP_IDX_W-1:0] grp_low_r   [GROUPS];
  logic [GROUP_IDX_W-1:0] grp_low_nxt [GROUPS];
  logic                   look_active_r;
  logic [GRP_W-1:0]       grp_sel;
  logic [SEL_W-1:0]       sel_wide;

  // Flag updates: clear wins, set and clear of a single tag otherwise.
  always_comb begin
    flags_nxt = flags_r;
    if (cmd.clear) begin
      flags_nxt = '0;
    end else begin
      if (cmd.set_en) flags_nxt[cmd.idx[IDX_W-1:0]] = 1'b1;
      if (cmd.clr_en) flags_nxt[cmd.idx[IDX_W-1:0]] = 1'b0;
    end
  end

  // Positions beyond the usable tags count as taken.
  always_comb begin
    for (int i = 0; i < NPAD; i++) begin
      busy_pad[i] = (i < TAGS_PER_HALF) ? flags_r[i] : 1'b1;
    end
  end

  // First search level: per group of eight, any free and lowest free.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_free_nxt[g] = ~&busy_pad[g*GROUP_SIZE +: GROUP_SIZE];
      grp_low_nxt[g]  = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (!busy_pad[g*GROUP_SIZE + b]) grp_low_nxt[g] = GROUP_IDX_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      look_active_r <= flags_r[look_idx];
      grp_free_r    <= grp_free_nxt;
      for (int g = 0; g < GROUPS; g++) grp_low_r[g] <= grp_low_nxt[g];
    end
  end

  // Second search level: lowest group with a free tag.
  always_comb begin
    grp_sel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_free_r[g]) grp_sel = GRP_W'(g);
    end
  end

  assign sel_wide    = {grp_sel, grp_low_r[grp_sel]};
  assign free_found  = |grp_free_r;
  assign free_idx    = sel_wide[IDX_W-1:0];
  assign look_active = look_active_r;

endmodule

@@ rtl/rta_page_ram.sv @@
// Page index store: single-port-write, single-read synchronous RAM with a
// registered read. Uses rta_pkg for the page width.
module rta_page_ram #(
  parameter int AW = 7
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rta_pkg::PAGE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rta_pkg::PAGE_W-1:0] rd_data
);
  import rta_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [PAGE_W-1:0] mem [DEPTH];
  logic [PAGE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/request_tag_allocator.sv @@
// Request tag allocator top level: command sequencer, count and half registers.
// Depends on rta_pkg, rta_flag_table and rta_page_ram.
//
//   channel   | handshake                 | word
//   ----------+---------------------------+------------------------------------
//   command   | start, busy (taken when   | in_func, in_tag_in, in_page_index,
//             | start & !busy)            | in_generation_half
//   result    | out_valid, one cycle      | out_ok, out_tag_out, out_page_out
//
// A command passes an accept cycle and then an execute cycle: the accept cycle
// reads the page RAM and registers the flag lookup and the first level of the
// free-tag search; the execute cycle (busy high) finishes the search, updates
// flags, RAM and count. The result word shows on the cycle after execute, while
// a new command may already be taken; no command is taken during execute.
// Reset clears all active flags at once, the count and the current half; the
// page RAM is not cleared. The receiver cannot stall: results are never held.
module request_tag_allocator #(
  parameter int TAGS_PER_HALF = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_func,
  input  logic [rta_pkg::TAG_W-1:0]  in_tag_in,
  input  logic [rta_pkg::PAGE_W-1:0] in_page_index,
  input  logic                       in_generation_half,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [rta_pkg::TAG_W-1:0]  out_tag_out,
  output logic [rta_pkg::PAGE_W-1:0] out_page_out
);
  import rta_pkg::*;

  // Index width inside a half; never below one bit.
  localparam int IDX_W = (TAGS_PER_HALF > 1) ? $clog2(TAGS_PER_HALF) : 1;

  rta_state_t         state_r, state_nxt;
  logic               accept;

  // Command word held for the execute cycle.
  logic [2:0]         func_r;
  logic [TAG_W-1:0]   tag_r;
  logic [PAGE_W-1:0]  page_r;
  logic               gen_half_r;
  logic               tag_in_range_r;

  logic [COUNT_W-1:0] active_count_r, active_count_nxt;
  logic               current_half_r, current_half_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic [PAGE_W-1:0]  out_page_r, out_page_nxt;

  rta_flag_cmd_t      flag_cmd;
  logic               look_active;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic               ram_wr_en;
  logic [PAGE_W-1:0]  ram_rd_data;
  logic               hit;

  assign accept = start && !busy;
  assign busy   = (state_r == ST_EXEC);

  rta_flag_table #(
    .TAGS_PER_HALF (TAGS_PER_HALF),
    .IDX_W         (IDX_W)
  ) u_flags (
    .clk         (clk),
    .rst_n       (rst_n),
    .capture     (accept),
    .look_idx    (in_tag_in[IDX_W-1:0]),
    .cmd         (flag_cmd),
    .look_active (look_active),
    .free_found  (free_found),
    .free_idx    (free_idx)
  );

  rta_page_ram #(
    .AW (IDX_W)
  ) u_pages (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (free_idx),
    .wr_data (page_r),
    .rd_en   (accept),
    .rd_addr (in_tag_in[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Capture the command word; tags past the usable range of a half never hit.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r         <= in_func;
      tag_r          <= in_tag_in;
      page_r         <= in_page_index;
      gen_half_r     <= in_generation_half;
      tag_in_range_r <= (in_tag_in[TAG_IDX_W-1:0] < TAG_IDX_W'(TAGS_PER_HALF - 1))
                        || (in_tag_in[TAG_IDX_W-1:0] == TAG_IDX_W'(TAGS_PER_HALF - 1));
    end
  end

  // Lookup hits only for an active tag of the current half.
  assign hit = (tag_r[TAG_W-1] == current_half_r) && tag_in_range_r && look_active;

  always_comb begin
    state_nxt        = state_r;
    active_count_nxt = active_count_r;
    current_half_nxt = current_half_r;
    out_valid_nxt    = 1'b0;
    out_ok_nxt       = out_ok_r;
    out_tag_nxt      = out_tag_r;
    out_page_nxt     = out_page_r;
    flag_cmd         = '0;
    ram_wr_en        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b0;
        out_tag_nxt   = '0;
        out_page_nxt  = '0;
        case (func_r)
          FN_BEGIN: begin
            // Drop every tag and switch to the requested half.
            flag_cmd.clear   = 1'b1;
            active_count_nxt = '0;
            current_half_nxt = gen_half_r;
            out_ok_nxt       = 1'b1;
          end
          FN_ASSIGN: begin
            if ((active_count_r < COUNT_W'(TAGS_PER_HALF)) && free_found) begin
              flag_cmd.set_en  = 1'b1;
              flag_cmd.idx     = TAG_IDX_W'(free_idx);
              ram_wr_en        = 1'b1;
              active_count_nxt = active_count_r + COUNT_W'(1);
              out_ok_nxt       = 1'b1;
              out_tag_nxt      = {current_half_r, TAG_IDX_W'(free_idx)};
            end
          end
          FN_RESOLVE: begin
            if (hit) begin
              out_ok_nxt   = 1'b1;
              out_page_nxt = ram_rd_data;
            end
          end
          FN_RETIRE: begin
            if (hit) begin
              flag_cmd.clr_en = 1'b1;
              flag_cmd.idx    = tag_r[TAG_IDX_W-1:0];
              if (active_count_r != '0) active_count_nxt = active_count_r - COUNT_W'(1);
              out_ok_nxt   = 1'b1;
              out_page_nxt = ram_rd_data;
            end
          end
          FN_INVALIDATE: begin
            // Drop every tag, keep the half.
            flag_cmd.clear   = 1'b1;
            active_count_nxt = '0;
            out_ok_nxt       = 1'b1;
          end
          default: begin
            // Unused codes answer a failed word and change nothing.
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      active_count_r <= '0;
      current_half_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      active_count_r <= active_count_nxt;
      current_half_r <= current_half_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r   <= out_ok_nxt;
    out_tag_r  <= out_tag_nxt;
    out_page_r <= out_page_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_tag_out  = out_tag_r;
  assign out_page_out = out_page_r;

  // Busy always drops after the execute cycle.
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("execute state held for more than one cycle");

  // A taken command is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted command not executed");

  // Every execute cycle yields exactly one result word.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid) else $error("result word missing after execute");

  // A failed result carries zero tag and page.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_tag_out == '0 && out_page_out == '0))
    else $error("failed result carries non-zero fields");

  // The count never passes the number of usable tags.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_count_r <= COUNT_W'(TAGS_PER_HALF)) else $error("active count overflow");

endmodule
